FILE: hdl/pwmhex_pkg.sv
// Shared constants and types for the PWM hex command parser.
package pwmhex_pkg;

	localparam int CHANNELS = 8;
	localparam int CHAN_W = 3;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int STEP_W = 3;

	localparam logic [7:0] CH_SYNC  = 8'h23;  // '#'
	localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
	localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
	localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
	localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
	localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
	localparam logic [7:0] CH_LZ    = 8'h7A;  // 'z'
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CASE_OFS = 8'h20;
	localparam logic [7:0] HEX_GAP  = 8'h07;

	// descriptor kinds
	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// last step of each reply
	localparam logic [STEP_W-1:0] STEP_OK_LAST  = 3'd5;
	localparam logic [STEP_W-1:0] STEP_ERR_LAST = 3'd6;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        echo;
		logic [CHAN_W-1:0] chan;
		logic [7:0]        value;
	} desc_t;

endpackage

FILE: hdl/pwmhex_front.sv
// Front end: parses received bytes and queues transmit descriptors.
module pwmhex_front
	import pwmhex_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       q_push,
	output desc_t      q_data
);

	localparam logic [1:0] PH_SYNC = 2'd0;
	localparam logic [1:0] PH_CHAN = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;
	localparam logic [1:0] PH_LOW  = 2'd3;

	logic [1:0]        phase_q;
	logic              err_q;
	logic [CHAN_W-1:0] chan_q;
	logic [3:0]        upper_q;

	logic              accept;
	logic [7:0]        c_up;
	logic              c_hex;
	logic [7:0]        c_adj;
	logic [3:0]        nib;
	logic [7:0]        chan_off;
	logic              chan_bad;

	assign rx_ready = !q_full;
	assign accept   = rx_valid && rx_ready;

	always_comb begin
		c_up     = ((rx_byte >= CH_LA) && (rx_byte <= CH_LZ)) ? rx_byte - CASE_OFS : rx_byte;
		c_hex    = ((c_up >= CH_ZERO) && (c_up <= CH_NINE)) ||
		           ((c_up >= CH_UA) && (c_up <= CH_UF));
		c_adj    = (c_up > CH_NINE) ? c_up - HEX_GAP : c_up;
		nib      = c_adj[3:0];  // '0' has a zero low nibble
		chan_off = rx_byte - CH_ZERO;
		chan_bad = (chan_off >= 8'(CHANNELS));
	end

	always_comb begin
		q_push = 1'b0;
		q_data = '{kind: KIND_ECHO, echo: rx_byte, chan: chan_q, value: {upper_q, nib}};
		unique case (phase_q)
			PH_SYNC: begin
				q_push = accept && (rx_byte == CH_SYNC);
			end
			PH_CHAN: begin
				q_push = accept;
			end
			PH_HIGH: begin
				q_push      = accept;
				q_data.echo = c_up;
			end
			PH_LOW: begin
				q_push      = accept;
				q_data.echo = c_up;
				q_data.kind = (err_q || !c_hex) ? KIND_ERR : KIND_OK;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			err_q   <= 1'b0;
			chan_q  <= '0;
			upper_q <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_SYNC: begin
					if (rx_byte == CH_SYNC) begin
						phase_q <= PH_CHAN;
						err_q   <= 1'b0;
					end
				end
				PH_CHAN: begin
					phase_q <= PH_HIGH;
					chan_q  <= chan_off[CHAN_W-1:0];
					if (chan_bad)
						err_q <= 1'b1;
				end
				PH_HIGH: begin
					phase_q <= PH_LOW;
					upper_q <= c_hex ? nib : 4'd0;
					if (!c_hex)
						err_q <= 1'b1;
				end
				PH_LOW: begin
					phase_q <= PH_SYNC;
					err_q   <= 1'b0;
				end
				default: begin
					phase_q <= PH_SYNC;
				end
			endcase
		end
	end

endmodule

FILE: hdl/pwmhex_queue.sv
// Small descriptor FIFO between the parser front end and the reply sequencer.
module pwmhex_queue
	import pwmhex_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output desc_t pop_data
);

	desc_t             entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count over depth");

endmodule

FILE: hdl/pwmhex_back.sv
// Back end: expands descriptors into transmit characters, one per transaction.
module pwmhex_back
	import pwmhex_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  desc_t             q_data,
	output logic              q_pop,
	output logic              tx_valid,
	input  logic              tx_ready,
	output logic [7:0]        tx_byte,
	output logic              last,
	output logic              pwm_write,
	output logic [CHAN_W-1:0] pwm_channel,
	output logic [7:0]        pwm_value
);

	desc_t             desc_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              done;

	assign tx_valid = busy_q;
	assign done     = busy_q && tx_ready && last;
	assign q_pop    = !q_empty && (!busy_q || done);

	always_comb begin
		tx_byte = desc_q.echo;
		unique case (desc_q.kind)
			KIND_OK: begin
				unique case (step_q)
					3'd1:    tx_byte = CH_COLON;
					3'd2:    tx_byte = CH_O;
					3'd3:    tx_byte = CH_K;
					3'd4:    tx_byte = CH_CR;
					3'd5:    tx_byte = CH_LF;
					default: tx_byte = desc_q.echo;
				endcase
			end
			KIND_ERR: begin
				unique case (step_q)
					3'd1:    tx_byte = CH_COLON;
					3'd2:    tx_byte = CH_E;
					3'd3:    tx_byte = CH_R;
					3'd4:    tx_byte = CH_R;
					3'd5:    tx_byte = CH_CR;
					3'd6:    tx_byte = CH_LF;
					default: tx_byte = desc_q.echo;
				endcase
			end
			default: tx_byte = desc_q.echo;
		endcase
	end

	always_comb begin
		unique case (desc_q.kind)
			KIND_OK:  last = (step_q == STEP_OK_LAST);
			KIND_ERR: last = (step_q == STEP_ERR_LAST);
			default:  last = 1'b1;
		endcase
		pwm_write   = (desc_q.kind == KIND_OK) && (step_q == STEP_OK_LAST);
		pwm_channel = pwm_write ? desc_q.chan : '0;
		pwm_value   = pwm_write ? desc_q.value : '0;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			desc_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && tx_ready) begin
			step_q <= step_q + 1'b1;
		end
	end

	a_hold_reply: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_ready && !last |=> tx_valid)
		else $error("reply cut short");

	a_write_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && pwm_write |-> last && (tx_byte == CH_LF))
		else $error("write reported off the final LF");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= STEP_ERR_LAST)
		else $error("reply step out of range");

endmodule

FILE: hdl/pwm_hex_command_parser.sv
// PWM hex command parser: echoes '#', channel digit and two hex nibbles, then
// answers ":OK" or ":ERR" with CR LF and reports accepted width writes. A received
// byte is taken whenever the two-entry descriptor queue has room; the transmit
// side sends one character per cycle while tx_ready is high, so an echo-only byte
// is one character and the final nibble expands to 6 (OK) or 7 (ERR) characters.
// Sustained command rate is set by the transmit sequencer draining each reply.
// The channel width registers live downstream, loaded on pwm_write.
module pwm_hex_command_parser
	import pwmhex_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  logic [7:0]        rx_byte,
	output logic              tx_valid,
	input  logic              tx_ready,
	output logic [7:0]        tx_byte,
	output logic              last,
	output logic              pwm_write,
	output logic [CHAN_W-1:0] pwm_channel,
	output logic [7:0]        pwm_value
);

	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	desc_t q_wdata;
	desc_t q_rdata;

	pwmhex_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	pwmhex_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_rdata)
	);

	pwmhex_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.tx_valid    (tx_valid),
		.tx_ready    (tx_ready),
		.tx_byte     (tx_byte),
		.last        (last),
		.pwm_write   (pwm_write),
		.pwm_channel (pwm_channel),
		.pwm_value   (pwm_value)
	);

endmodule

FILE: bench/pwm_hex_command_parser_tb.sv
// Self-checking testbench for the PWM hex command parser.
`timescale 1ns / 1ps

module pwm_hex_command_parser_tb;
	import pwmhex_pkg::*;

	localparam int LONG_HOLD   = 150;
	localparam int STUCK_LIMIT = 2000;
	localparam int PAUSE_CYC   = 25;

	typedef enum logic [1:0] {ST_SYNC, ST_CHAN, ST_HIGH, ST_LOW} parse_state_t;

	typedef struct {
		logic [7:0]        tx_byte;
		logic              last;
		logic              pwm_write;
		logic [CHAN_W-1:0] pwm_channel;
		logic [7:0]        pwm_value;
	} reply_char_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              rx_valid = 1'b0;
	logic              rx_ready;
	logic [7:0]        rx_byte = 8'h00;
	logic              tx_valid;
	logic              tx_ready = 1'b0;
	logic [7:0]        tx_byte;
	logic              last;
	logic              pwm_write;
	logic [CHAN_W-1:0] pwm_channel;
	logic [7:0]        pwm_value;

	// predictor state
	parse_state_t parse_st = ST_SYNC;
	logic [7:0]   target_chan = 8'h00;
	logic         cmd_err = 1'b0;
	logic [3:0]   hi_nib = 4'h0;
	logic [7:0]   chan_width [CHANNELS];

	reply_char_t reply_chars [$];
	logic [7:0]  rx_pending [$];
	int          rx_queued = 0;
	int          rx_taken = 0;
	int          rx_gap = 0;
	int          tx_stall = 0;
	int          hold_left = 0;
	int          hold_req = 0;
	int          hold_ack = 0;
	bit          quiet_tail = 1'b0;
	int          mismatches = 0;
	int          stuck_cycles = 0;

	pwm_hex_command_parser i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.tx_valid    (tx_valid),
		.tx_ready    (tx_ready),
		.tx_byte     (tx_byte),
		.last        (last),
		.pwm_write   (pwm_write),
		.pwm_channel (pwm_channel),
		.pwm_value   (pwm_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 60)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void queue_char(input logic [7:0] ch, input logic lst,
		input logic wr, input logic [CHAN_W-1:0] chn, input logic [7:0] val);
		reply_char_t r;
		r.tx_byte     = ch;
		r.last        = lst;
		r.pwm_write   = wr;
		r.pwm_channel = chn;
		r.pwm_value   = val;
		reply_chars.push_back(r);
	endfunction

	// expected transmit characters for one received byte
	function automatic void predict_reply(input logic [7:0] b);
		logic [7:0] c;
		logic       hex_ok;
		logic [3:0] nib;
		logic [7:0] val;
		c = b;
		if (b >= CH_LA && b <= CH_LZ)
			c = b - CASE_OFS;
		hex_ok = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UF);
		nib = (c <= CH_NINE) ? c[3:0] : c[3:0] + 4'd9;
		case (parse_st)
			ST_SYNC: begin
				if (b == CH_SYNC) begin
					cmd_err = 1'b0;
					queue_char(b, 1'b1, 1'b0, '0, 8'h00);
					parse_st = ST_CHAN;
				end
			end
			ST_CHAN: begin
				target_chan = b - CH_ZERO;
				if (target_chan >= CHANNELS)
					cmd_err = 1'b1;
				queue_char(b, 1'b1, 1'b0, '0, 8'h00);
				parse_st = ST_HIGH;
			end
			ST_HIGH: begin
				hi_nib = hex_ok ? nib : 4'h0;
				if (!hex_ok)
					cmd_err = 1'b1;
				queue_char(c, 1'b1, 1'b0, '0, 8'h00);
				parse_st = ST_LOW;
			end
			default: begin
				if (!hex_ok)
					cmd_err = 1'b1;
				val = {hi_nib, hex_ok ? nib : 4'h0};
				queue_char(c, 1'b0, 1'b0, '0, 8'h00);
				queue_char(CH_COLON, 1'b0, 1'b0, '0, 8'h00);
				if (!cmd_err) begin
					chan_width[target_chan[CHAN_W-1:0]] = val;
					queue_char(CH_O, 1'b0, 1'b0, '0, 8'h00);
					queue_char(CH_K, 1'b0, 1'b0, '0, 8'h00);
					queue_char(CH_CR, 1'b0, 1'b0, '0, 8'h00);
					queue_char(CH_LF, 1'b1, 1'b1, target_chan[CHAN_W-1:0], val);
				end else begin
					queue_char(CH_E, 1'b0, 1'b0, '0, 8'h00);
					queue_char(CH_R, 1'b0, 1'b0, '0, 8'h00);
					queue_char(CH_R, 1'b0, 1'b0, '0, 8'h00);
					queue_char(CH_CR, 1'b0, 1'b0, '0, 8'h00);
					queue_char(CH_LF, 1'b1, 1'b0, '0, 8'h00);
				end
				cmd_err = 1'b0;
				parse_st = ST_SYNC;
			end
		endcase
	endfunction

	task automatic check_tx();
		reply_char_t e;
		if (reply_chars.size() == 0) begin
			report_mismatch($sformatf("unexpected tx_byte %02h", tx_byte));
		end else begin
			e = reply_chars.pop_front();
			if (tx_byte !== e.tx_byte)
				report_mismatch($sformatf("tx_byte %02h, want %02h", tx_byte, e.tx_byte));
			if (last !== e.last)
				report_mismatch($sformatf("last %b, want %b", last, e.last));
			if (pwm_write !== e.pwm_write)
				report_mismatch($sformatf("pwm_write %b, want %b", pwm_write, e.pwm_write));
			if (pwm_channel !== e.pwm_channel)
				report_mismatch($sformatf("pwm_channel %0d, want %0d",
					pwm_channel, e.pwm_channel));
			if (pwm_value !== e.pwm_value)
				report_mismatch($sformatf("pwm_value %02h, want %02h",
					pwm_value, e.pwm_value));
		end
	endtask

	// rx driver: one transaction per pending byte, random gap bursts
	always @(posedge clk) begin : rx_driver
		logic       nxt_valid;
		logic [7:0] nxt_byte;
		nxt_valid = rx_valid;
		nxt_byte  = rx_byte;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else begin
			if (rx_valid && rx_ready) begin
				predict_reply(rx_byte);
				rx_taken++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (rx_gap != 0) begin
					rx_gap--;
				end else if (rx_pending.size() != 0) begin
					if (!quiet_tail && $urandom_range(0, 6) == 0) begin
						rx_gap = $urandom_range(0, 8);
					end else begin
						nxt_valid = 1'b1;
						nxt_byte  = rx_pending.pop_front();
					end
				end
			end
		end
		rx_valid <= nxt_valid;
		rx_byte  <= nxt_byte;
	end

	// tx monitor and ready generator
	always @(posedge clk) begin : tx_monitor
		logic nxt_ready;
		nxt_ready = 1'b0;
		if (arst_n) begin
			if (tx_valid && tx_ready)
				check_tx();
			if (hold_left != 0) begin
				hold_left--;
			end else if (hold_req != hold_ack) begin
				hold_ack  = hold_req;
				hold_left = LONG_HOLD;
			end else if (tx_stall != 0) begin
				tx_stall--;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				tx_stall = $urandom_range(0, 8);
			end else begin
				nxt_ready = 1'b1;
			end
		end
		tx_ready <= nxt_ready;
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_valid && rx_ready) || (tx_valid && tx_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		rx_pending.push_back(b);
		rx_queued++;
	endtask

	task automatic send_cmd(input logic [7:0] ch, input logic [7:0] hi, input logic [7:0] lo);
		send_byte(CH_SYNC);
		send_byte(ch);
		send_byte(hi);
		send_byte(lo);
	endtask

	function automatic logic [7:0] pick_channel_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return CH_ZERO + 8'($urandom_range(0, CHANNELS - 1));
		else if (r < 17)
			return CH_ZERO + 8'($urandom_range(CHANNELS, 9));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_nibble_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return CH_ZERO + 8'($urandom_range(0, 9));
		else if (r < 8)
			return (CH_UA + 8'($urandom_range(0, 5))) | ($urandom_range(0, 1) ? CASE_OFS : 8'h00);
		return 8'($urandom_range(0, 255));
	endfunction

	// idle noise now and then, then a command with random content
	task automatic send_random_cmd();
		logic [7:0] junk;
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				junk = 8'($urandom_range(0, 255));
				send_byte((junk == CH_SYNC) ? ~junk : junk);
			end
		end
		send_cmd(pick_channel_char(), pick_nibble_char(), pick_nibble_char());
	endtask

	task automatic wait_drained();
		while (!(rx_taken == rx_queued && reply_chars.size() == 0))
			@(negedge clk);
	endtask

	initial begin
		foreach (chan_width[i])
			chan_width[i] = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// noise while idle, then boundaries of channel and nibble decoding
		send_byte(8'h00);
		send_byte(8'hFF);
		send_cmd(CH_ZERO, CH_ZERO, CH_ZERO);
		send_cmd(CH_ZERO + 8'd7, 8'h66, CH_UF);
		send_cmd(CH_ZERO + 8'd8, 8'h31, 8'h32);
		send_cmd(8'hFF, CH_LA, 8'h62);
		send_cmd(8'h2F, 8'h67, 8'h80);
		send_cmd(CH_ZERO + 8'd3, CH_NINE, CH_LZ);
		wait_drained();
		repeat (PAUSE_CYC) @(posedge clk);

		// long receiver hold while the sender keeps offering bytes
		repeat (30) send_random_cmd();
		@(negedge clk);
		hold_req++;
		repeat (40) send_random_cmd();
		wait_drained();
		repeat (PAUSE_CYC) @(posedge clk);

		@(negedge clk);
		quiet_tail = 1'b1;
		repeat (50) send_random_cmd();
		wait_drained();
		repeat (30) @(posedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
hdl/pwmhex_pkg.sv
hdl/pwmhex_front.sv
hdl/pwmhex_queue.sv
hdl/pwmhex_back.sv
hdl/pwm_hex_command_parser.sv
bench/pwm_hex_command_parser_tb.sv
